/* rtl/fit_strategy_block_allocator_defines.svh */
// Assertion macros for the fit-strategy block allocator checker.
// Depends on nothing; the asserting scope must provide clk and rst_n.
`ifndef FIT_STRATEGY_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIT_STRATEGY_BLOCK_ALLOCATOR_DEFINES_SVH

// Check on every rising edge outside reset.
`define FSBA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check on every rising edge, reset included.
`define FSBA_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/fsba_pkg.sv */
// Shared constants, codes and the result record of the block allocator.
// No dependencies.
`timescale 1ns / 1ps

package fsba_pkg;

    localparam int DEF_MAX_SEGMENTS = 64;
    localparam int DEF_SIZE_WIDTH   = 16;
    localparam int POOL_RESET       = 4096;

    localparam int ACT_W      = 2;
    localparam int REQ_W      = 16;
    localparam int STAT_W     = 2;
    localparam int OUT_IDX_W  = 6;
    localparam int OUT_SIZE_W = 16;

    localparam logic [ACT_W-1:0] ACT_FIRST = 2'd0;
    localparam logic [ACT_W-1:0] ACT_BEST  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_WORST = 2'd2;
    localparam logic [ACT_W-1:0] ACT_FREE  = 2'd3;

    localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_FIT = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] ST_NONE   = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0]     status;
        logic [OUT_IDX_W-1:0]  index;
        logic [OUT_SIZE_W-1:0] size;
        logic [OUT_SIZE_W-1:0] start;
    } result_t;

endpackage

/* rtl/fsba_seg_mem.sv */
// Segment table storage: one write port, one read port, registered read data.
// Depends on fsba_pkg for default sizes.
`timescale 1ns / 1ps

module fsba_seg_mem #(
    parameter int DEPTH = fsba_pkg::DEF_MAX_SEGMENTS,
    parameter int WIDTH = fsba_pkg::DEF_SIZE_WIDTH + 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/fsba_ctrl.sv */
// Allocator sequencer: scan, decide, shift-insert and result register.
// Depends on fsba_pkg; drives the ports of fsba_seg_mem.
`timescale 1ns / 1ps

module fsba_ctrl #(
    parameter int MAX_SEGMENTS = fsba_pkg::DEF_MAX_SEGMENTS,
    parameter int SIZE_WIDTH   = fsba_pkg::DEF_SIZE_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [15:0]                     cfg_wr_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [fsba_pkg::ACT_W-1:0]      in_action,
    input  logic [fsba_pkg::REQ_W-1:0]      in_req,
    output logic                            out_valid,
    input  logic                            out_ready,
    output fsba_pkg::result_t               out_result,
    output logic                            mem_we,
    output logic [$clog2(MAX_SEGMENTS)-1:0] mem_waddr,
    output logic [SIZE_WIDTH:0]             mem_wdata,
    output logic                            mem_re,
    output logic [$clog2(MAX_SEGMENTS)-1:0] mem_raddr,
    input  logic [SIZE_WIDTH:0]             mem_rdata
);

    import fsba_pkg::*;

    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int CMP_W = (SIZE_WIDTH > REQ_W) ? SIZE_WIDTH : REQ_W;

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_SPLIT  = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]            state_reg,      state_next;
    logic [SIZE_WIDTH-1:0] pool_reg,       pool_next;
    logic [CNT_W-1:0]      count_reg,      count_next;
    logic [ACT_W-1:0]      action_reg,     action_next;
    logic [REQ_W-1:0]      req_reg,        req_next;
    logic [CNT_W-1:0]      rd_ptr_reg,     rd_ptr_next;
    logic                  rd_pend_reg,    rd_pend_next;
    logic [IDX_W-1:0]      data_idx_reg,   data_idx_next;
    logic [SIZE_WIDTH-1:0] sum_reg,        sum_next;
    logic                  found_reg,      found_next;
    logic [IDX_W-1:0]      pick_reg,       pick_next;
    logic [SIZE_WIDTH-1:0] pick_size_reg,  pick_size_next;
    logic [SIZE_WIDTH-1:0] pick_start_reg, pick_start_next;
    result_t               result_reg,     result_next;
    logic                  out_valid_reg,  out_valid_next;
    result_t               out_result_reg, out_result_next;

    logic                  ent_free;
    logic [SIZE_WIDTH-1:0] ent_size;
    logic                  fits;
    logic                  take;
    logic                  issue;
    logic [IDX_W-1:0]      last_idx;
    logic                  need_split;
    logic [SIZE_WIDTH-1:0] req_sz;
    result_t               pick_result;

    assign ent_free   = mem_rdata[SIZE_WIDTH];
    assign ent_size   = mem_rdata[SIZE_WIDTH-1:0];
    assign fits       = ent_free && (CMP_W'(ent_size) >= CMP_W'(req_reg));
    assign last_idx   = IDX_W'(count_reg - 1'b1);
    assign need_split = CMP_W'(pick_size_reg) > CMP_W'(req_reg);
    assign req_sz     = SIZE_WIDTH'(req_reg);

    always_comb
    begin
        pick_result.status = ST_DONE;
        pick_result.index  = OUT_IDX_W'(pick_reg);
        pick_result.size   = OUT_SIZE_W'(pick_size_reg);
        pick_result.start  = OUT_SIZE_W'(pick_start_reg);
    end

    // A free takes the first allocated entry; allocates follow the fit rule.
    always_comb
    begin
        if (action_reg == ACT_FREE)
        begin
            take = !ent_free && !found_reg;
        end
        else
        begin
            take = fits && (!found_reg
                || (action_reg == ACT_BEST  && ent_size < pick_size_reg)
                || (action_reg == ACT_WORST && ent_size > pick_size_reg));
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        pool_next       = pool_reg;
        count_next      = count_reg;
        action_next     = action_reg;
        req_next        = req_reg;
        rd_ptr_next     = rd_ptr_reg;
        rd_pend_next    = 1'b0;
        data_idx_next   = data_idx_reg;
        sum_next        = sum_reg;
        found_next      = found_reg;
        pick_next       = pick_reg;
        pick_size_next  = pick_size_reg;
        pick_start_next = pick_start_reg;
        result_next     = result_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_result_next = out_result_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        issue           = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = {1'b1, pool_reg};
                count_next = CNT_W'(1);
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    action_next = in_action;
                    req_next    = in_req;
                    rd_ptr_next = '0;
                    sum_next    = '0;
                    found_next  = 1'b0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                issue = rd_ptr_reg < count_reg;
                if (issue)
                begin
                    rd_ptr_next   = rd_ptr_reg + 1'b1;
                    rd_pend_next  = 1'b1;
                    data_idx_next = IDX_W'(rd_ptr_reg);
                end
                if (rd_pend_reg)
                begin
                    sum_next = sum_reg + ent_size;
                    if (take)
                    begin
                        found_next      = 1'b1;
                        pick_next       = data_idx_reg;
                        pick_size_next  = ent_size;
                        pick_start_next = sum_reg;
                    end
                    if (data_idx_reg == last_idx)
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE:
            begin
                state_next = S_DONE;
                if (!found_reg)
                begin
                    result_next        = '0;
                    result_next.status = (action_reg == ACT_FREE) ? ST_NONE : ST_NO_FIT;
                end
                else if (action_reg == ACT_FREE)
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = pick_reg;
                    mem_wdata   = {1'b1, pick_size_reg};
                    result_next = pick_result;
                end
                else if (!need_split)
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = pick_reg;
                    mem_wdata   = {1'b0, pick_size_reg};
                    result_next = pick_result;
                end
                else if (count_reg == CNT_W'(MAX_SEGMENTS))
                begin
                    result_next        = pick_result;
                    result_next.status = ST_FULL;
                end
                else
                begin
                    // Move entries above the pick up by one, top entry first.
                    rd_ptr_next = count_reg - 1'b1;
                    state_next  = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                issue = rd_ptr_reg > CNT_W'(pick_reg);
                if (issue)
                begin
                    rd_ptr_next   = rd_ptr_reg - 1'b1;
                    rd_pend_next  = 1'b1;
                    data_idx_next = IDX_W'(rd_ptr_reg);
                end
                if (rd_pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = IDX_W'(data_idx_reg + 1'b1);
                    mem_wdata = mem_rdata;
                end
                if (!issue && !rd_pend_reg)
                begin
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = IDX_W'(pick_reg + 1'b1);
                mem_wdata  = {1'b1, pick_size_reg - req_sz};
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                mem_we           = 1'b1;
                mem_waddr        = pick_reg;
                mem_wdata        = {1'b0, req_sz};
                count_next       = count_reg + 1'b1;
                result_next      = pick_result;
                result_next.size = OUT_SIZE_W'(req_sz);
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_result_next = result_reg;
                    state_next      = S_IDLE;
                end
            end
        endcase

        if (cfg_wr_en)
        begin
            pool_next  = SIZE_WIDTH'(cfg_wr_data);
            state_next = S_INIT;
        end
    end

    assign mem_re    = issue;
    assign mem_raddr = IDX_W'(rd_ptr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            pool_reg      <= SIZE_WIDTH'(POOL_RESET);
            count_reg     <= CNT_W'(1);
            rd_pend_reg   <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pool_reg      <= pool_next;
            count_reg     <= count_next;
            rd_pend_reg   <= rd_pend_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        req_reg        <= req_next;
        rd_ptr_reg     <= rd_ptr_next;
        data_idx_reg   <= data_idx_next;
        sum_reg        <= sum_next;
        pick_reg       <= pick_next;
        pick_size_reg  <= pick_size_next;
        pick_start_reg <= pick_start_next;
        result_reg     <= result_next;
        out_result_reg <= out_result_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

endmodule

/* rtl/fit_strategy_block_allocator.sv */
// Each request scans all n entries (n = segment count) and then decides; a free, a refusal
// or an exact fit ends there, while a split first moves the entries above the pick up by one,
// then writes the free remainder and the allocated part. Throughput: one transaction at a time;
// the next input can be taken from the cycle the result is presented, later while a result is held.
// Reset (rst_n low, asynchronous) and any pool_size write pass through an init state that
// reloads entry zero with a free segment spanning the pool; no input is taken then.
`timescale 1ns / 1ps

module fit_strategy_block_allocator #(
    parameter int MAX_SEGMENTS = fsba_pkg::DEF_MAX_SEGMENTS,
    parameter int SIZE_WIDTH   = fsba_pkg::DEF_SIZE_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,  // pool_size
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,      // request_size
    input  logic [1:0]  s_tuser,      // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,      // segment_index, segment_size, segment_start, zero pad
    output logic [1:0]  m_tuser       // status
);

    import fsba_pkg::*;

    localparam int IDX_W = $clog2(MAX_SEGMENTS);

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [SIZE_WIDTH:0]   mem_wdata;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_raddr;
    logic [SIZE_WIDTH:0]   mem_rdata;
    result_t               result;

    fsba_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .SIZE_WIDTH   (SIZE_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_action   (s_tuser),
        .in_req      (s_tdata),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (result),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    fsba_seg_mem #(
        .DEPTH (MAX_SEGMENTS),
        .WIDTH (SIZE_WIDTH + 1)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign m_tdata = {2'b00, result.start, result.size, result.index};
    assign m_tuser = result.status;

endmodule

/* rtl/fsba_checker.sv */
// Port-level checks of the block allocator, bound to the top level.
// Depends on fsba_pkg and fit_strategy_block_allocator_defines.svh.
`timescale 1ns / 1ps

`include "fit_strategy_block_allocator_defines.svh"

module fsba_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_wr_en,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,   // segment_index, segment_size, segment_start, zero pad
    input logic [1:0]  m_tuser    // status
);

    import fsba_pkg::*;

    // A stalled result holds.
    `FSBA_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // One transaction at a time: no acceptance in the cycle after one.
    `FSBA_ASSERT(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready, "input accepted while busy")

    // Refusals without a segment carry an all-zero payload.
    `FSBA_ASSERT(a_refusal_zero, m_tvalid && (m_tuser == ST_NO_FIT || m_tuser == ST_NONE) |-> m_tdata == 40'd0, "refusal with nonzero payload")

    // A pool write reloads the table before any input is taken.
    `FSBA_ASSERT(a_cfg_blocks_input, cfg_wr_en |=> !s_tready, "input ready right after a pool write")

    // Nothing is presented in the cycle after reset is seen.
    `FSBA_ASSERT_RST(a_reset_quiet, !rst_n |=> !m_tvalid && !s_tready, "activity after reset")

endmodule

bind fit_strategy_block_allocator fsba_checker u_fsba_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);

/* sim/fit_strategy_block_allocator_tb.sv */
// Self-checking testbench for fit_strategy_block_allocator: segment table predictor,
// randomized stream driver and monitor, and pool-size reconfiguration between phases.
// Depends on fsba_pkg and the fit_strategy_block_allocator RTL.
`timescale 1ns / 1ps

module fit_strategy_block_allocator_tb;

    import fsba_pkg::*;

    localparam int TABLE_DEPTH    = DEF_MAX_SEGMENTS;
    localparam int DRAIN_CYCLES   = 2 * DEF_MAX_SEGMENTS + 20;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [REQ_W-1:0] size;
    } alloc_op_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = 16'd0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = 16'd0;
    logic [1:0]  s_tuser     = 2'd0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    // Predicted segment table
    logic [OUT_SIZE_W-1:0] seg_sizes [TABLE_DEPTH];
    bit                    seg_free  [TABLE_DEPTH];
    int unsigned           seg_count;

    alloc_op_t request_backlog[$];
    result_t   awaited_grants[$];

    int  mismatches    = 0;
    int  ops_sent      = 0;
    int  grants_seen   = 0;
    int  pool_writes   = 0;
    int  status_hits[4] = '{0, 0, 0, 0};
    int  idle_cycles   = 0;
    int  send_gap      = 0;
    int  stall_left    = 0;
    bit  send_burst    = 1'b0;
    bit  recv_burst    = 1'b0;

    fit_strategy_block_allocator DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic void reload_table(input logic [15:0] pool);
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            seg_sizes[i] = '0;
            seg_free[i]  = 1'b0;
        end
        seg_sizes[0] = pool;
        seg_free[0]  = 1'b1;
        seg_count    = 1;
    endfunction

    function automatic result_t describe_segment(input logic [STAT_W-1:0] status,
                                                 input int unsigned idx);
        result_t               r;
        logic [OUT_SIZE_W-1:0] offset;
        offset = '0;
        for (int i = 0; i < idx; i++)
            offset += seg_sizes[i];
        r.status = status;
        r.index  = idx[OUT_IDX_W-1:0];
        r.size   = seg_sizes[idx];
        r.start  = offset;
        return r;
    endfunction

    // Apply one request to the predicted table and return the grant it produces.
    function automatic result_t serve_request(input logic [ACT_W-1:0] action,
                                              input logic [REQ_W-1:0] req);
        result_t     r;
        int unsigned n;
        int unsigned pick;
        bit          found;
        r     = '0;
        n     = seg_count;
        pick  = 0;
        found = 1'b0;
        if (action == ACT_FREE)
        begin
            for (int unsigned i = 0; i < n; i++)
            begin
                if (!seg_free[i])
                begin
                    seg_free[i] = 1'b1;
                    return describe_segment(ST_DONE, i);
                end
            end
            r.status = ST_NONE;
            return r;
        end
        for (int unsigned i = 0; i < n; i++)
        begin
            if (seg_free[i] && seg_sizes[i] >= req && !(found && action == ACT_FIRST))
            begin
                if (!found)
                begin
                    pick  = i;
                    found = 1'b1;
                end
                else if (action == ACT_BEST && seg_sizes[i] < seg_sizes[pick])
                    pick = i;
                else if (action == ACT_WORST && seg_sizes[i] > seg_sizes[pick])
                    pick = i;
            end
        end
        if (!found)
        begin
            r.status = ST_NO_FIT;
            return r;
        end
        if (seg_sizes[pick] > req)
        begin
            if (n >= TABLE_DEPTH)
                return describe_segment(ST_FULL, pick);
            for (int unsigned i = n; i > pick + 1; i--)
            begin
                seg_sizes[i] = seg_sizes[i-1];
                seg_free[i]  = seg_free[i-1];
            end
            seg_sizes[pick+1] = seg_sizes[pick] - req;
            seg_free[pick+1]  = 1'b1;
            seg_sizes[pick]   = req;
            seg_count         = n + 1;
        end
        seg_free[pick] = 1'b0;
        return describe_segment(ST_DONE, pick);
    endfunction

    // Mostly short gaps, a few long ones; none while a burst stretch is on.
    function automatic int pick_gap(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Stream driver
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        alloc_op_t op;
        logic      hold_valid;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            hold_valid = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                awaited_grants.push_back(serve_request(s_tuser, s_tdata));
                ops_sent++;
                hold_valid = 1'b0;
            end
            if (!hold_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (request_backlog.size() > 0)
                begin
                    op = request_backlog.pop_front();
                    s_tdata    <= op.size;
                    s_tuser    <= op.action;
                    hold_valid = 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        send_burst = ~send_burst;
                    send_gap = pick_gap(send_burst);
                end
            end
            s_tvalid <= hold_valid;
        end
    end

    // Result monitor
    always @(posedge clk or negedge rst_n)
    begin : check_grants
        result_t seen;
        result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen.status = m_tuser;
                seen.index  = m_tdata[5:0];
                seen.size   = m_tdata[21:6];
                seen.start  = m_tdata[37:22];
                grants_seen++;
                status_hits[seen.status]++;
                if (awaited_grants.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("ERROR: unexpected result status=%0d index=%0d size=%0d start=%0d",
                                 seen.status, seen.index, seen.size, seen.start);
                end
                else
                begin
                    want = awaited_grants.pop_front();
                    if (seen.status != want.status || seen.index != want.index ||
                        seen.size != want.size || seen.start != want.start)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"ERROR: result %0d expected status=%0d index=%0d ",
                                      "size=%0d start=%0d, got status=%0d index=%0d ",
                                      "size=%0d start=%0d"},
                                     grants_seen, want.status, want.index, want.size,
                                     want.start, seen.status, seen.index, seen.size,
                                     seen.start);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 39) == 0)
                    recv_burst = ~recv_burst;
                if ($urandom_range(0, 5) == 0)
                    stall_left = pick_gap(recv_burst);
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                     idle_cycles, awaited_grants.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic add_op(input logic [ACT_W-1:0] action, input logic [REQ_W-1:0] size);
        alloc_op_t op;
        op.action = action;
        op.size   = size;
        request_backlog.push_back(op);
    endtask

    // Sample at the falling edge so the driver's and monitor's updates have settled.
    task automatic wait_idle();
        @(negedge clk);
        while (request_backlog.size() != 0 || s_tvalid || awaited_grants.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_pool(input logic [15:0] pool);
        wait_idle();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= pool;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        reload_table(pool);
        pool_writes++;
        @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] pool_plan [8];
        int          phase_len;
        int          pool;
        int          r;
        logic [15:0] palette [4];
        logic [15:0] size;
        logic [1:0]  action;

        reload_table(16'(POOL_RESET));
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: default pool of 4096
        add_op(ACT_FREE, 16'd5);        // nothing allocated yet
        add_op(ACT_FIRST, 16'd100);     // split
        add_op(ACT_BEST, 16'd4096);     // no fit
        add_op(ACT_WORST, 16'd3996);    // exact fit of the remainder
        add_op(ACT_BEST, 16'd1);        // everything allocated
        add_op(ACT_FREE, 16'hFFFF);
        add_op(ACT_FREE, 16'd0);
        add_op(ACT_FREE, 16'd0);        // nothing left to free
        add_op(ACT_FIRST, 16'd0);       // zero-size allocation splits the whole segment
        add_op(ACT_WORST, 16'hFFFF);    // larger than any segment
        add_op(ACT_BEST, 16'd50);
        add_op(ACT_WORST, 16'd10);
        add_op(ACT_BEST, 16'd3996);
        add_op(ACT_FIRST, 16'd40);

        // Directed: empty pool
        write_pool(16'd0);
        add_op(ACT_FIRST, 16'd0);
        add_op(ACT_WORST, 16'd1);
        add_op(ACT_FREE, 16'd0);
        add_op(ACT_BEST, 16'd0);

        pool_plan = '{16'hFFFF, 16'd1, 16'd0, 16'd4096, 16'd300, 16'hFFFF, 16'd2, 16'd40000};
        pool_plan[4] = 16'($urandom_range(100, 2000));
        pool_plan[7] = 16'($urandom_range(2000, 65534));

        foreach (pool_plan[p])
        begin
            write_pool(pool_plan[p]);
            pool      = pool_plan[p];
            phase_len = (pool < 4) ? 60 : 190;
            // A few recurring sizes make freed segments get reused by exact fits.
            foreach (palette[k])
                palette[k] = 16'($urandom_range(1, pool / 40 + 1));
            for (int i = 0; i < phase_len; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    size = 16'd0;
                else if (r < 55)
                    size = palette[$urandom_range(0, 3)];
                else if (r < 80)
                    size = 16'($urandom_range(1, pool / 32 + 1));
                else if (r < 92)
                    size = 16'($urandom_range(0, pool));
                else
                    size = 16'($urandom);
                r = $urandom_range(0, 99);
                if (r < 22)
                    action = ACT_FREE;
                else if (r < 48)
                    action = ACT_FIRST;
                else if (r < 74)
                    action = ACT_BEST;
                else
                    action = ACT_WORST;
                add_op(action, size);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests over %0d pool sizes, %0d results checked",
                 ops_sent, pool_writes + 1, grants_seen);
        $display("Status counts: done=%0d no_fit=%0d full=%0d none_to_free=%0d, mismatches=%0d",
                 status_hits[ST_DONE], status_hits[ST_NO_FIT], status_hits[ST_FULL],
                 status_hits[ST_NONE], mismatches);
        if (mismatches == 0 && awaited_grants.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* fit_strategy_block_allocator.f */
+incdir+rtl
rtl/fsba_pkg.sv
rtl/fsba_seg_mem.sv
rtl/fsba_ctrl.sv
rtl/fit_strategy_block_allocator.sv
rtl/fsba_checker.sv
sim/fit_strategy_block_allocator_tb.sv
